FILE: hw/rtl/keyed_record_table_top_macros.svh
// Assertion macros shared by the keyed record table RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef KEYED_RECORD_TABLE_TOP_MACROS_SVH
`define KEYED_RECORD_TABLE_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define KRT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("check failed");
`define KRT_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");
`else
`define KRT_ASSERT(lbl, clk, rstn, prop)
`define KRT_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

FILE: hw/rtl/krt_pkg.sv
// Shared types for the keyed record table: request codes, status codes,
// back-end states and the queued item format. No dependencies.
`default_nettype none

package krt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_MODIFY = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_EXEC = 1'b1
  } back_state_e;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned NameW   = 64;
  localparam int unsigned AmountW = 32;
  localparam int unsigned PosW    = 4;
  localparam int unsigned FillW   = 5;

  typedef struct packed {
    op_e                        op;
    logic signed [KeyW-1:0]     key;
    logic [NameW-1:0]           name;
    logic signed [AmountW-1:0]  amount;
  } krt_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/krt_front.sv
// Front end: accepts request items, decodes the request code and holds
// them in a two-entry queue for the back end. Uses krt_pkg.
`default_nettype none

module krt_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic signed [krt_pkg::KeyW-1:0]    key_i,
  input  wire logic [krt_pkg::NameW-1:0]          name_word_i,
  input  wire logic signed [krt_pkg::AmountW-1:0] pay_amount_i,
  output logic                              head_valid_o,
  output krt_pkg::krt_item_t                head_o,
  input  wire logic                         pop_i
);

  krt_pkg::krt_item_t mem_q [2];
  krt_pkg::krt_item_t item;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  always_comb begin
    item.op     = krt_pkg::op_e'(req_type_i);
    item.key    = key_i;
    item.name   = name_word_i;
    item.amount = pay_amount_i;
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign pop          = pop_i && head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/krt_back.sv
// Back end: record table in registers, parallel key compare, insert,
// search, modify and compacting delete, and the result register. Uses krt_pkg.
`default_nettype none
`include "keyed_record_table_top_macros.svh"

module krt_back #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               head_valid_i,
  input  wire krt_pkg::krt_item_t                 head_i,
  output logic                                    pop_o,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              status_o,
  output logic [krt_pkg::PosW-1:0]                position_o,
  output logic [krt_pkg::NameW-1:0]               found_name_o,
  output logic signed [krt_pkg::AmountW-1:0]      found_amount_o,
  output logic [krt_pkg::FillW-1:0]               fill_level_o
);

  localparam int unsigned IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // table storage, no reset: only entries below count_q are ever read
  logic signed [krt_pkg::KeyW-1:0]    key_q    [TABLE_DEPTH];
  logic [krt_pkg::NameW-1:0]          name_q   [TABLE_DEPTH];
  logic signed [krt_pkg::AmountW-1:0] amount_q [TABLE_DEPTH];

  logic [CntW-1:0]          count_q, count_d;
  krt_pkg::back_state_e     state_q, state_d;
  krt_pkg::krt_item_t       cur_q;
  logic [TABLE_DEPTH-1:0]   hit_q, hit_d;
  logic [TABLE_DEPTH-1:0]   at_or_after, first_hit, shift_en;
  logic [IdxW-1:0]          pos;
  logic                     found, full, out_free, exec_fire;
  logic                     ins_ok, mod_ok, del_ok;
  logic [krt_pkg::NameW-1:0]          sel_name;
  logic signed [krt_pkg::AmountW-1:0] sel_amount;
  krt_pkg::status_e         status_d;
  logic [krt_pkg::PosW-1:0] position_d;

  logic                               out_valid_q;
  krt_pkg::status_e                   status_q;
  logic [krt_pkg::PosW-1:0]           position_q;
  logic [krt_pkg::NameW-1:0]          found_name_q;
  logic signed [krt_pkg::AmountW-1:0] found_amount_q;
  logic [krt_pkg::FillW-1:0]          fill_level_q;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign exec_fire = (state_q == krt_pkg::BK_EXEC) && out_free;

  // match vector against the queue head, limited to live entries
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_d[i] = (key_q[i] == head_i.key) && (CntW'(i) < count_q);
    end
  end

  // first match: prefix OR, then edge to one-hot
  always_comb begin
    at_or_after[0] = hit_q[0];
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      at_or_after[i] = at_or_after[i-1] | hit_q[i];
    end
    first_hit = at_or_after & ~(at_or_after << 1);
    found     = at_or_after[TABLE_DEPTH-1];
    pos        = '0;
    sel_name   = '0;
    sel_amount = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_hit[i]) begin
        pos        = pos | IdxW'(i);
        sel_name   = sel_name | name_q[i];
        sel_amount = sel_amount | amount_q[i];
      end
      shift_en[i] = at_or_after[i] && (CntW'(i + 1) < count_q);
    end
  end

  assign full   = (count_q >= CntW'(TABLE_DEPTH));
  assign ins_ok = (cur_q.op == krt_pkg::OP_INSERT) && !full && !found;
  assign mod_ok = (cur_q.op == krt_pkg::OP_MODIFY) && found;
  assign del_ok = (cur_q.op == krt_pkg::OP_DELETE) && found;

  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    count_d    = count_q;
    status_d   = krt_pkg::ST_OK;
    position_d = krt_pkg::PosW'(pos);
    case (state_q)
      krt_pkg::BK_IDLE: begin
        if (head_valid_i) begin
          pop_o   = 1'b1;
          state_d = krt_pkg::BK_EXEC;
        end
      end
      krt_pkg::BK_EXEC: begin
        if (out_free) state_d = krt_pkg::BK_IDLE;
      end
      default: state_d = krt_pkg::BK_IDLE;
    endcase

    case (cur_q.op)
      krt_pkg::OP_INSERT: begin
        if (full) begin
          status_d   = krt_pkg::ST_FULL;
          position_d = '0;
        end else if (found) begin
          status_d = krt_pkg::ST_EXISTS;
        end else begin
          position_d = krt_pkg::PosW'(count_q);
        end
      end
      default: begin
        if (!found) begin
          status_d   = krt_pkg::ST_NOT_FOUND;
          position_d = '0;
        end
      end
    endcase

    if (exec_fire && ins_ok) count_d = count_q + CntW'(1);
    if (exec_fire && del_ok) count_d = count_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= krt_pkg::BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (exec_fire)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
      hit_q <= hit_d;
    end
    if (exec_fire) begin
      status_q     <= status_d;
      position_q   <= position_d;
      fill_level_q <= krt_pkg::FillW'(count_d);
      if ((cur_q.op == krt_pkg::OP_SEARCH) && found) begin
        found_name_q   <= sel_name;
        found_amount_q <= sel_amount;
      end else begin
        found_name_q   <= '0;
        found_amount_q <= '0;
      end
    end
  end

  // per-entry writes: append, overwrite in place, or pull down from above
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
    always_ff @(posedge clk_i) begin
      if (exec_fire) begin
        if (ins_ok && (count_q == CntW'(g))) begin
          key_q[g]    <= cur_q.key;
          name_q[g]   <= cur_q.name;
          amount_q[g] <= cur_q.amount;
        end else if (mod_ok && first_hit[g]) begin
          name_q[g]   <= cur_q.name;
          amount_q[g] <= cur_q.amount;
        end else if (del_ok && shift_en[g]) begin
          if (g + 1 < TABLE_DEPTH) begin
            key_q[g]    <= key_q[(g + 1) % TABLE_DEPTH];
            name_q[g]   <= name_q[(g + 1) % TABLE_DEPTH];
            amount_q[g] <= amount_q[(g + 1) % TABLE_DEPTH];
          end
        end
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign position_o     = position_q;
  assign found_name_o   = found_name_q;
  assign found_amount_o = found_amount_q;
  assign fill_level_o   = fill_level_q;

  `KRT_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(TABLE_DEPTH))
  `KRT_ASSERT(a_del_shrinks, clk_i, rst_ni, (exec_fire && del_ok) |=> (count_q == $past(count_q) - CntW'(1)))
  `KRT_ASSERT(a_fill_matches, clk_i, rst_ni, exec_fire |=> (fill_level_o == krt_pkg::FillW'(count_q)))
  `KRT_ASSERT_NEVER(a_pop_in_exec, clk_i, rst_ni, pop_o && (state_q == krt_pkg::BK_EXEC))

endmodule

`default_nettype wire

FILE: hw/rtl/keyed_record_table_top.sv
// Keyed record table: up to TABLE_DEPTH records (key, 64-bit name word,
// salary) kept in insertion order, serving insert, search, modify and
// delete requests; delete closes the gap by moving later records down.
// For each item the back end first compares the key against every live entry
// in parallel and registers the match vector, then picks the first match and
// updates the table and result register. A two-entry queue decouples the
// input from the back end, so requests keep arriving while a result waits;
// the back end takes the next item only after the last reaches the result
// register. Status: 0 ok, 1 not found, 2 key exists, 3 table full.
// Depends on krt_pkg, krt_front and krt_back.
`default_nettype none

module keyed_record_table_top #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [1:0]                         req_type_i,
  input  wire logic signed [krt_pkg::KeyW-1:0]    key_i,
  input  wire logic [krt_pkg::NameW-1:0]          name_word_i,
  input  wire logic signed [krt_pkg::AmountW-1:0] pay_amount_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [1:0]                              status_o,
  output logic [krt_pkg::PosW-1:0]                position_o,
  output logic [krt_pkg::NameW-1:0]               found_name_o,
  output logic signed [krt_pkg::AmountW-1:0]      found_amount_o,
  output logic [krt_pkg::FillW-1:0]               fill_level_o
);

  logic               head_valid;
  logic               pop;
  krt_pkg::krt_item_t head;

  krt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .name_word_i  (name_word_i),
    .pay_amount_i (pay_amount_i),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  krt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .position_o     (position_o),
    .found_name_o   (found_name_o),
    .found_amount_o (found_amount_o),
    .fill_level_o   (fill_level_o)
  );

endmodule

`default_nettype wire
